FILE: src/fdmadb_pkg.sv
// ----------------------------------------------------------------------------
// fdmadb_pkg
// Types and constants shared by the disk DMA double-buffer block.
// ----------------------------------------------------------------------------
package fdmadb_pkg;

    localparam int BUF_BYTES = 16;
    localparam int BUF_WORDS = BUF_BYTES / 2;
    localparam int FILL_W    = $clog2(BUF_BYTES + 1);
    localparam int WIDX_W    = $clog2(BUF_WORDS);
    localparam int MEM_AW    = WIDX_W + 1;
    localparam int MEM_DEPTH = 2 * BUF_WORDS;
    localparam int CNT_W     = MEM_AW;
    localparam int MOVED_W   = 5;

    localparam int CTL_DIR_BIT     = 8;
    localparam int CTL_DRQ_SRC_BIT = 7;
    localparam int CTL_CNT_SEL_BIT = 4;
    localparam int CTL_HDC_BIT     = 3;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_FDC   = 2'd2,
        CMD_GRANT = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        REG_DATA    = 3'd2,
        REG_CTRL    = 3'd3,
        REG_ADDR_HI = 3'd4,
        REG_ADDR_MD = 3'd5,
        REG_ADDR_LO = 3'd6
    } t_reg;

    typedef enum logic {
        S_IDLE  = 1'b0,
        S_DRAIN = 1'b1
    } t_state;

    typedef struct packed {
        t_cmd        cmd;
        logic [2:0]  reg_addr;
        logic [15:0] write_data;
        logic [7:0]  fdc_data;
        logic        fdc_drq;
        logic        fdc_irq;
    } t_in_item;

    typedef struct packed {
        logic [15:0]        read_data;
        logic               fdc_write_strobe;
        logic [1:0]         fdc_reg_sel;
        logic [7:0]         fdc_write_data;
        logic               ram_write_valid;
        logic [22:0]        ram_word_addr;
        logic [15:0]        ram_write_data;
        logic [MOVED_W-1:0] words_moved;
        logic               bus_request;
        logic               irq_line;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic             item_go;
        logic             word_go;
        logic             last_word;
        logic [CNT_W-1:0] rd_cnt;
    } t_dp_cmd;

    typedef struct packed {
        logic [MOVED_W-1:0] grant_words;
        logic               out_free;
    } t_dp_sts;

endpackage

FILE: src/fdmadb_ctrl.sv
// ----------------------------------------------------------------------------
// fdmadb_ctrl
// Item acceptance and drain sequencing for the disk DMA double-buffer block.
// ----------------------------------------------------------------------------
module fdmadb_ctrl import fdmadb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_last_cnt, n_last_cnt;
    logic             w_accept;
    logic             w_word_go;
    logic             w_last_word;

    assign o_in_stall  = !((r_state == S_IDLE) && i_sts.out_free);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_word_go   = (r_state == S_DRAIN) && i_sts.out_free;
    assign w_last_word = (r_cnt == r_last_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_last_cnt <= '0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_last_cnt <= n_last_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (i_sts.grant_words != '0)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (w_word_go && w_last_word) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_cnt      = r_cnt;
        n_last_cnt = r_last_cnt;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                n_cnt         = '0;
                o_cmd.item_go = w_accept;
                if (w_accept && (i_sts.grant_words != '0)) begin
                    n_last_cnt = CNT_W'(i_sts.grant_words - MOVED_W'(1));
                end
            end
            S_DRAIN: begin
                o_cmd.word_go   = w_word_go;
                o_cmd.last_word = w_last_word;
                if (w_word_go) begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            default: n_cnt = '0;
        endcase
        o_cmd.rd_cnt = n_cnt;
    end

endmodule

FILE: src/fdmadb_dp.sv
// ----------------------------------------------------------------------------
// fdmadb_dp
// Registers, byte buffers, DMA address and result register of the disk DMA
// double-buffer block.
// ----------------------------------------------------------------------------
module fdmadb_dp import fdmadb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [23:0] i_cfg_wr_data,
    input  t_in_item    i_item,
    input  t_dp_cmd     i_cmd,
    output t_dp_sts     o_sts,
    input  logic        i_out_stall,
    output logic        o_out_valid,
    output t_out_item   o_out
);

    logic [23:0]        r_ram_size;
    logic [15:0]        r_ctl, n_ctl;
    logic [16:0]        r_left, n_left;
    logic [23:0]        r_dma, n_dma;
    logic [FILL_W-1:0]  r_fill, n_fill;
    logic               r_active, n_active;
    logic [1:0]         r_full, n_full;
    logic               r_overrun, n_overrun;
    logic               r_irq, n_irq;
    logic               r_busreq, n_busreq;
    logic [MOVED_W-1:0] r_moved, n_moved;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [7:0]         mem_hi [MEM_DEPTH];
    logic [7:0]         mem_lo [MEM_DEPTH];
    logic [7:0]         r_rd_hi, r_rd_lo;

    logic [MOVED_W-1:0] w_k;
    logic               w_out_free;
    logic               w_res_now;
    logic               w_load;
    t_out_item          w_res;
    t_out_item          w_word;
    t_out_item          w_load_item;
    logic               w_we;
    logic [MEM_AW-1:0]  w_waddr;
    logic [MEM_AW-1:0]  w_raddr;
    logic [FILL_W-1:0]  w_fill_inc;
    logic [15:0]        w_count_rd;
    logic [23:0]        w_dma_mid;
    logic [23:0]        w_dma_lo;
    logic [23:0]        w_dma_step;
    logic [22:0]        w_waddr_word;
    logic               w_drq_take;

    assign w_k = (!r_ctl[CTL_DIR_BIT] && r_full[~r_active])
               ? (r_full[r_active] ? MOVED_W'(2 * BUF_WORDS) : MOVED_W'(BUF_WORDS))
               : '0;

    assign w_out_free        = !r_out_valid || !i_out_stall;
    assign o_sts.out_free    = w_out_free;
    assign o_sts.grant_words = (i_item.cmd == CMD_GRANT) ? w_k : '0;

    assign w_count_rd = 16'((18'(r_left) + 18'd511) >> 9);
    assign w_dma_mid  = (r_dma[15] && !i_item.write_data[7]) ? r_dma + 24'h010000 : r_dma;
    assign w_dma_lo   = (r_dma[7] && !i_item.write_data[7]) ? r_dma + 24'h000100 : r_dma;
    assign w_dma_step = r_dma + 24'd2;
    assign w_fill_inc = (r_fill < FILL_W'(BUF_BYTES)) ? r_fill + FILL_W'(1) : r_fill;
    assign w_drq_take = (r_left != '0) && i_item.fdc_drq && r_ctl[CTL_DRQ_SRC_BIT];
    assign w_waddr    = {r_active, r_fill[WIDX_W:1]};
    assign w_raddr    = {~r_active ^ i_cmd.rd_cnt[CNT_W-1], i_cmd.rd_cnt[WIDX_W-1:0]};
    assign w_waddr_word = r_dma[23:1];

    always_comb begin
        n_ctl     = r_ctl;
        n_left    = r_left;
        n_dma     = r_dma;
        n_fill    = r_fill;
        n_active  = r_active;
        n_full    = r_full;
        n_overrun = r_overrun;
        n_irq     = r_irq;
        n_busreq  = r_busreq;
        n_moved   = r_moved;
        w_we      = 1'b0;
        w_res_now = 1'b1;
        w_res     = '0;
        w_res.read_data = 16'hffff;
        w_res.last      = 1'b1;
        if (i_cmd.item_go) begin
            case (i_item.cmd)
                CMD_READ: begin
                    case (i_item.reg_addr)
                        REG_DATA: begin
                            if (r_ctl[CTL_CNT_SEL_BIT]) begin
                                w_res.read_data = w_count_rd;
                            end else if (r_ctl[CTL_HDC_BIT]) begin
                                w_res.read_data = 16'hffff;
                            end else begin
                                w_res.read_data = {8'hff, i_item.fdc_data};
                            end
                        end
                        REG_CTRL: begin
                            w_res.read_data = {13'h1fff, i_item.fdc_drq, (r_left != '0),
                                               !r_overrun};
                        end
                        REG_ADDR_HI: w_res.read_data = {8'hff, r_dma[23:16]};
                        REG_ADDR_MD: w_res.read_data = {8'hff, r_dma[15:8]};
                        REG_ADDR_LO: w_res.read_data = {8'hff, r_dma[7:0]};
                        default:     w_res.read_data = 16'hffff;
                    endcase
                end
                CMD_WRITE: begin
                    case (i_item.reg_addr)
                        REG_DATA: begin
                            if (r_ctl[CTL_CNT_SEL_BIT]) begin
                                n_left = {i_item.write_data[7:0], 9'd0};
                            end else if (!r_ctl[CTL_HDC_BIT]) begin
                                w_res.fdc_write_strobe = 1'b1;
                                w_res.fdc_write_data   = i_item.write_data[7:0];
                            end
                        end
                        REG_CTRL: begin
                            if (r_ctl[CTL_DIR_BIT] != i_item.write_data[CTL_DIR_BIT]) begin
                                n_fill    = '0;
                                n_active  = 1'b0;
                                n_overrun = 1'b0;
                                n_left    = '0;
                            end
                            n_ctl = i_item.write_data;
                        end
                        REG_ADDR_HI: n_dma = {i_item.write_data[7:0], r_dma[15:0]};
                        REG_ADDR_MD: n_dma = {w_dma_mid[23:16], i_item.write_data[7:0],
                                              w_dma_mid[7:0]};
                        REG_ADDR_LO: n_dma = {w_dma_lo[23:8], i_item.write_data[7:1], 1'b0};
                        default: n_dma = r_dma;
                    endcase
                end
                CMD_FDC: begin
                    n_irq = i_item.fdc_irq;
                    if (w_drq_take) begin
                        n_left = r_left - 17'd1;
                        if (!r_ctl[CTL_DIR_BIT]) begin
                            w_we   = (r_fill < FILL_W'(BUF_BYTES));
                            n_fill = w_fill_inc;
                            if (w_fill_inc == FILL_W'(BUF_BYTES)) begin
                                n_full[r_active] = 1'b1;
                                if (r_full[~r_active]) begin
                                    n_overrun = 1'b1;
                                end else begin
                                    n_fill   = '0;
                                    n_active = ~r_active;
                                end
                                n_busreq = 1'b1;
                            end
                        end
                    end
                end
                CMD_GRANT: begin
                    n_busreq = 1'b0;
                    n_moved  = w_k;
                    if (w_k != '0) begin
                        w_res_now         = 1'b0;
                        n_full[~r_active] = 1'b0;
                        if (r_full[r_active]) begin
                            n_full[r_active] = 1'b0;
                            n_fill           = '0;
                        end
                    end
                end
                default: w_res_now = 1'b1;
            endcase
            w_res.fdc_reg_sel = n_ctl[2:1];
            w_res.bus_request = n_busreq;
            w_res.irq_line    = n_irq;
        end else if (i_cmd.word_go) begin
            n_dma = w_dma_step;
        end
    end

    always_comb begin
        w_word                 = '0;
        w_word.read_data       = 16'hffff;
        w_word.fdc_reg_sel     = r_ctl[2:1];
        w_word.ram_write_valid = ({1'b0, w_waddr_word} < r_ram_size);
        w_word.ram_word_addr   = w_waddr_word;
        w_word.ram_write_data  = {r_rd_hi, r_rd_lo};
        w_word.words_moved     = r_moved;
        w_word.bus_request     = 1'b0;
        w_word.irq_line        = r_irq;
        w_word.last            = i_cmd.last_word;
    end

    assign w_load      = (i_cmd.item_go && w_res_now) || i_cmd.word_go;
    assign w_load_item = i_cmd.word_go ? w_word : w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_size  <= 24'd262144;
            r_ctl       <= '0;
            r_left      <= '0;
            r_dma       <= '0;
            r_fill      <= '0;
            r_active    <= 1'b0;
            r_full      <= '0;
            r_overrun   <= 1'b0;
            r_irq       <= 1'b0;
            r_busreq    <= 1'b0;
            r_moved     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_ram_size <= i_cfg_wr_data;
            end
            r_ctl     <= n_ctl;
            r_left    <= n_left;
            r_dma     <= n_dma;
            r_fill    <= n_fill;
            r_active  <= n_active;
            r_full    <= n_full;
            r_overrun <= n_overrun;
            r_irq     <= n_irq;
            r_busreq  <= n_busreq;
            r_moved   <= n_moved;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_load_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we && !r_fill[0]) begin
            mem_hi[w_waddr] <= i_item.fdc_data;
        end
        if (w_we && r_fill[0]) begin
            mem_lo[w_waddr] <= i_item.fdc_data;
        end
        r_rd_hi <= mem_hi[w_raddr];
        r_rd_lo <= mem_lo[w_raddr];
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

FILE: src/floppy_dma_double_buffer.sv
// ----------------------------------------------------------------------------
// floppy_dma_double_buffer
// Disk DMA controller with two 16-byte read buffers drained to RAM as
// big-endian words on a bus grant.
//
//   channel   direction   handshake                 beat
//   in        to block    i_in_valid / o_in_stall   t_in_item
//   out       from block  o_out_valid / i_out_stall t_out_item
//   cfg       to block    i_cfg_wr_en               ram_size_words
//
// Register, disk-event and empty-grant items: one result beat each.
// A grant that drains moves 8 or 16 words, one beat per cycle while out is not
// stalled, from the buffer RAM's registered read port; no item is taken during a drain.
// Reset is synchronous; buffer contents are not cleared.
// A stall on out holds the result register and stalls in.
// ----------------------------------------------------------------------------
module floppy_dma_double_buffer import fdmadb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [23:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    fdmadb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    fdmadb_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_item        (i_in_data),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_out         (o_out_data)
    );

    a_no_accept_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.word_go |-> !(i_in_valid && !o_in_stall))
        else $error("item accepted during drain");

    a_ram_write_in_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.ram_write_valid |-> o_out_data.words_moved != '0)
        else $error("ram write outside a grant");

    a_grant_drops_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.words_moved != '0) |-> !o_out_data.bus_request)
        else $error("bus request held on grant beat");

    a_multi_only_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last |-> o_out_data.words_moved != '0)
        else $error("non-final beat outside a drain");

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the disk DMA double-buffer block. Register, disk
// event and grant beats go in over the valid/stall channel. An in-bench model
// of the registers, byte buffers and address counter predicts every result
// beat, including the RAM word writes of each grant. Each result beat is
// compared field by field. Random gaps and stalls run on both channels.
// ----------------------------------------------------------------------------
module tb;
    import fdmadb_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 100;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [23:0] i_cfg_wr_data = '0;
    logic        i_in_valid    = 1'b0;
    t_in_item    i_in_data     = '0;
    logic        i_out_stall   = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_item   o_out_data;

    int send_gap_pct = 0;
    int stall_pct    = 0;
    int items_sent   = 0;
    int mismatches   = 0;

    t_out_item beats_due [$];
    t_out_item drain_words [$];

    logic [15:0] ctl_word      = '0;
    logic [16:0] bytes_pending = '0;
    logic [23:0] dma_addr      = '0;
    logic [23:0] ram_words     = 24'd262144;
    int          fill_level    = 0;
    bit          fill_buf      = 1'b0;
    logic [7:0]  stash [2*BUF_BYTES];
    bit          stash_full [2];
    bit          overrun       = 1'b0;
    bit          irq_level     = 1'b0;
    bit          bus_req       = 1'b0;

    floppy_dma_double_buffer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_data     (i_in_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_data    (o_out_data)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic t_in_item in_beat(t_cmd c, logic [2:0] r, logic [15:0] wd,
                                         logic [7:0] fd, logic drq, logic irq);
        t_in_item it;
        it.cmd        = c;
        it.reg_addr   = r;
        it.write_data = wd;
        it.fdc_data   = fd;
        it.fdc_drq    = drq;
        it.fdc_irq    = irq;
        return it;
    endfunction

    function automatic t_out_item plain_beat();
        t_out_item b;
        b             = '0;
        b.read_data   = 16'hffff;
        b.fdc_reg_sel = ctl_word[2:1];
        b.bus_request = bus_req;
        b.irq_line    = irq_level;
        return b;
    endfunction

    function automatic logic [15:0] reg_value(logic [2:0] r, logic [7:0] fd, logic drq);
        logic [17:0] rounded;
        rounded = {1'b0, bytes_pending} + 18'd511;
        case (r)
            REG_DATA: begin
                if (ctl_word[CTL_CNT_SEL_BIT]) return {7'd0, rounded[17:9]};
                if (ctl_word[CTL_HDC_BIT]) return 16'hffff;
                return {8'hff, fd};
            end
            REG_CTRL:    return {13'h1fff, drq, bytes_pending != 0, !overrun};
            REG_ADDR_HI: return {8'hff, dma_addr[23:16]};
            REG_ADDR_MD: return {8'hff, dma_addr[15:8]};
            REG_ADDR_LO: return {8'hff, dma_addr[7:0]};
            default:     return 16'hffff;
        endcase
    endfunction

    function automatic logic reg_store(logic [2:0] r, logic [15:0] v);
        case (r)
            REG_DATA: begin
                if (!ctl_word[CTL_CNT_SEL_BIT]) return !ctl_word[CTL_HDC_BIT];
                bytes_pending = {v[7:0], 9'd0};
            end
            REG_CTRL: begin
                if (ctl_word[CTL_DIR_BIT] != v[CTL_DIR_BIT]) begin
                    fill_level    = 0;
                    fill_buf      = 1'b0;
                    overrun       = 1'b0;
                    bytes_pending = '0;
                end
                ctl_word = v;
            end
            REG_ADDR_HI: dma_addr[23:16] = v[7:0];
            REG_ADDR_MD: begin
                if (dma_addr[15] && !v[7]) dma_addr = dma_addr + 24'h010000;
                dma_addr[15:8] = v[7:0];
            end
            REG_ADDR_LO: begin
                if (dma_addr[7] && !v[7]) dma_addr = dma_addr + 24'h000100;
                dma_addr[7:0] = {v[7:1], 1'b0};
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    task automatic disk_event(logic [7:0] fd, logic drq, logic irq);
        int base;
        irq_level = irq;
        if (bytes_pending == 0 || !drq || !ctl_word[CTL_DRQ_SRC_BIT]) return;
        bytes_pending = bytes_pending - 17'd1;
        if (ctl_word[CTL_DIR_BIT]) return;
        base = fill_buf ? BUF_BYTES : 0;
        if (fill_level < BUF_BYTES) begin
            stash[base + fill_level] = fd;
            fill_level++;
        end
        if (fill_level == BUF_BYTES) begin
            stash_full[fill_buf] = 1'b1;
            if (stash_full[!fill_buf]) begin
                overrun = 1'b1;
            end else begin
                fill_level = 0;
                fill_buf   = !fill_buf;
            end
            bus_req = 1'b1;
        end
    endtask

    task automatic drain_stash(bit which);
        int          base;
        logic [22:0] waddr;
        t_out_item   b;
        base = which ? BUF_BYTES : 0;
        for (int c = 0; c < BUF_BYTES / 2; c++) begin
            waddr             = dma_addr[23:1];
            b                 = plain_beat();
            b.ram_write_valid = ({1'b0, waddr} < ram_words);
            b.ram_word_addr   = waddr;
            b.ram_write_data  = {stash[base + 2*c], stash[base + 2*c + 1]};
            drain_words.push_back(b);
            dma_addr = dma_addr + 24'd2;
        end
        stash_full[which] = 1'b0;
    endtask

    task automatic grant_beats();
        t_out_item b;
        bus_req = 1'b0;
        drain_words.delete();
        if (!ctl_word[CTL_DIR_BIT] && stash_full[!fill_buf]) begin
            drain_stash(!fill_buf);
            if (stash_full[fill_buf]) begin
                drain_stash(fill_buf);
                fill_level = 0;
            end
        end
        if (drain_words.size() == 0) begin
            b      = plain_beat();
            b.last = 1'b1;
            beats_due.push_back(b);
        end else begin
            for (int i = 0; i < drain_words.size(); i++) begin
                b             = drain_words[i];
                b.words_moved = MOVED_W'(drain_words.size());
                b.bus_request = 1'b0;
                b.last        = (i == drain_words.size() - 1);
                beats_due.push_back(b);
            end
        end
    endtask

    task automatic predict_dma_beats(t_in_item it);
        t_out_item b;
        logic      strobe;
        case (it.cmd)
            CMD_READ: begin
                b           = plain_beat();
                b.read_data = reg_value(it.reg_addr, it.fdc_data, it.fdc_drq);
                b.last      = 1'b1;
                beats_due.push_back(b);
            end
            CMD_WRITE: begin
                strobe             = reg_store(it.reg_addr, it.write_data);
                b                  = plain_beat();
                b.fdc_write_strobe = strobe;
                b.fdc_write_data   = strobe ? it.write_data[7:0] : 8'h00;
                b.last             = 1'b1;
                beats_due.push_back(b);
            end
            CMD_FDC: begin
                disk_event(it.fdc_data, it.fdc_drq, it.fdc_irq);
                b      = plain_beat();
                b.last = 1'b1;
                beats_due.push_back(b);
            end
            default: grant_beats();
        endcase
    endtask

    function automatic string describe(t_out_item b);
        return $sformatf("rd=%h stb=%b sel=%0d wd=%h wv=%b wa=%h ww=%h n=%0d br=%b irq=%b last=%b",
                         b.read_data, b.fdc_write_strobe, b.fdc_reg_sel, b.fdc_write_data,
                         b.ram_write_valid, b.ram_word_addr, b.ram_write_data, b.words_moved,
                         b.bus_request, b.irq_line, b.last);
    endfunction

    function automatic bit beat_matches(t_out_item e, t_out_item g);
        return (e.read_data === g.read_data) && (e.fdc_write_strobe === g.fdc_write_strobe)
            && (e.fdc_reg_sel === g.fdc_reg_sel) && (e.fdc_write_data === g.fdc_write_data)
            && (e.ram_write_valid === g.ram_write_valid)
            && (e.ram_word_addr === g.ram_word_addr)
            && (e.ram_write_data === g.ram_write_data) && (e.words_moved === g.words_moved)
            && (e.bus_request === g.bus_request) && (e.irq_line === g.irq_line)
            && (e.last === g.last);
    endfunction

    always @(posedge i_clk) begin : check_beats
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (beats_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected beat %s", $realtime, describe(o_out_data));
            end else begin
                want = beats_due.pop_front();
                if (!beat_matches(want, o_out_data)) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: beat mismatch", $realtime);
                        $display("  expected %s", describe(want));
                        $display("  actual   %s", describe(o_out_data));
                    end
                end
            end
        end
    end

    task automatic send_item(t_in_item it);
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_dma_beats(it);
        items_sent++;
    endtask

    task automatic set_ram_words(logic [23:0] words);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (beats_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= words;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        ram_words = words;
    endtask

    function automatic logic [23:0] pick_ram_words();
        case ($urandom_range(3))
            0:       return 24'h000000;
            1:       return 24'h800000;
            2:       return 24'($urandom_range(24'h800000));
            default: return 24'({1'b0, dma_addr[23:1]} + $urandom_range(12));
        endcase
    endfunction

    task automatic send_noise();
        repeat (6) begin
            send_item(in_beat(t_cmd'($urandom_range(3)), 3'($urandom_range(7)),
                              16'($urandom_range(16'hffff)), 8'($urandom_range(8'hff)),
                              1'($urandom_range(1)), 1'($urandom_range(1))));
        end
    endtask

    task automatic dma_read_burst();
        logic [15:0] ctl;
        logic [15:0] count;
        int          pick;
        bit          hold_grants;
        send_item(in_beat(CMD_WRITE, REG_ADDR_HI, 16'($urandom_range(16'hffff)), 8'h00,
                          1'b0, 1'b0));
        send_item(in_beat(CMD_WRITE, REG_ADDR_MD, 16'($urandom_range(16'hffff)), 8'h00,
                          1'b0, 1'b0));
        send_item(in_beat(CMD_WRITE, REG_ADDR_LO, 16'($urandom_range(16'hffff)), 8'h00,
                          1'b0, 1'b0));
        if ($urandom_range(2) == 0) set_ram_words(pick_ram_words());
        ctl                  = 16'($urandom_range(16'hffff));
        ctl[CTL_DIR_BIT]     = ($urandom_range(7) == 0);
        ctl[CTL_DRQ_SRC_BIT] = ($urandom_range(9) != 0);
        ctl[CTL_CNT_SEL_BIT] = 1'b1;
        send_item(in_beat(CMD_WRITE, REG_CTRL, ctl, 8'h00, 1'b0, 1'b0));
        count      = 16'($urandom_range(16'hffff));
        count[7:0] = ($urandom_range(9) == 0) ? 8'h00 : 8'($urandom_range(2, 1));
        send_item(in_beat(CMD_WRITE, REG_DATA, count, 8'h00, 1'b0, 1'b0));
        if ($urandom_range(1)) begin
            ctl[CTL_CNT_SEL_BIT] = 1'b0;
            send_item(in_beat(CMD_WRITE, REG_CTRL, ctl, 8'h00, 1'b0, 1'b0));
        end
        hold_grants = ($urandom_range(3) == 0);
        repeat ($urandom_range(44, 8)) begin
            pick = $urandom_range(99);
            if (pick < 76)
                send_item(in_beat(CMD_FDC, 3'($urandom_range(7)),
                                  16'($urandom_range(16'hffff)),
                                  8'($urandom_range(8'hff)), 1'b1, 1'($urandom_range(1))));
            else if (pick < 83)
                send_item(in_beat(CMD_FDC, 3'($urandom_range(7)),
                                  16'($urandom_range(16'hffff)),
                                  8'($urandom_range(8'hff)), 1'b0, 1'($urandom_range(1))));
            else if (pick < 90 && !hold_grants)
                send_item(in_beat(CMD_GRANT, 3'd0, 16'h0000, 8'h00, 1'b0, 1'b0));
            else
                send_item(in_beat(CMD_READ, 3'($urandom_range(7)),
                                  16'($urandom_range(16'hffff)),
                                  8'($urandom_range(8'hff)), 1'($urandom_range(1)), 1'b0));
        end
        send_item(in_beat(CMD_GRANT, 3'd0, 16'h0000, 8'h00, 1'b0, 1'b0));
        if ($urandom_range(1))
            send_item(in_beat(CMD_GRANT, 3'd0, 16'h0000, 8'h00, 1'b0, 1'b0));
    endtask

    task automatic test_register_map();
        for (int r = 0; r < 8; r++) begin
            send_item(in_beat(CMD_READ, r[2:0], 16'h0000, r[0] ? 8'hff : 8'h00, r[0], r[1]));
        end
    endtask

    task automatic test_address_carry();
        send_item(in_beat(CMD_WRITE, REG_ADDR_HI, 16'hffff, 8'h00, 1'b0, 1'b0));
        send_item(in_beat(CMD_WRITE, REG_ADDR_MD, 16'h0080, 8'h00, 1'b0, 1'b0));
        send_item(in_beat(CMD_WRITE, REG_ADDR_LO, 16'h00ff, 8'h00, 1'b0, 1'b0));
        send_item(in_beat(CMD_WRITE, REG_ADDR_MD, 16'h7f00, 8'h00, 1'b0, 1'b0));
        send_item(in_beat(CMD_WRITE, REG_ADDR_LO, 16'h0001, 8'h00, 1'b0, 1'b0));
        send_item(in_beat(CMD_READ, REG_ADDR_HI, 16'h0000, 8'h00, 1'b0, 1'b0));
        send_item(in_beat(CMD_READ, REG_ADDR_MD, 16'h0000, 8'h00, 1'b0, 1'b0));
        send_item(in_beat(CMD_READ, REG_ADDR_LO, 16'h0000, 8'h00, 1'b0, 1'b0));
    endtask

    task automatic test_count_and_target();
        send_item(in_beat(CMD_WRITE, REG_CTRL, 16'h0010, 8'h00, 1'b0, 1'b0));
        send_item(in_beat(CMD_WRITE, REG_DATA, 16'ha5ff, 8'h00, 1'b0, 1'b0));
        send_item(in_beat(CMD_READ, REG_DATA, 16'h0000, 8'h00, 1'b0, 1'b0));
        send_item(in_beat(CMD_READ, REG_CTRL, 16'h0000, 8'h00, 1'b1, 1'b0));
        send_item(in_beat(CMD_WRITE, REG_CTRL, 16'h0108, 8'h00, 1'b0, 1'b0));
        send_item(in_beat(CMD_READ, REG_DATA, 16'h0000, 8'h5a, 1'b0, 1'b0));
        send_item(in_beat(CMD_WRITE, REG_DATA, 16'h5a5a, 8'h00, 1'b0, 1'b0));
        send_item(in_beat(CMD_WRITE, REG_CTRL, 16'h0006, 8'h00, 1'b0, 1'b0));
        send_item(in_beat(CMD_WRITE, REG_DATA, 16'h12c3, 8'h00, 1'b0, 1'b0));
        send_item(in_beat(CMD_READ, REG_CTRL, 16'h0000, 8'h00, 1'b0, 1'b0));
    endtask

    task automatic test_events_and_empty_grant();
        send_item(in_beat(CMD_FDC, 3'd0, 16'h0000, 8'h3c, 1'b1, 1'b1));
        send_item(in_beat(CMD_GRANT, 3'd0, 16'h0000, 8'h00, 1'b0, 1'b0));
    endtask

    task automatic test_transfers(int gap, int stall, logic [23:0] first_words);
        int start;
        send_gap_pct = gap;
        stall_pct    = stall;
        set_ram_words(first_words);
        start = items_sent;
        while (items_sent - start < PHASE_ITEMS) begin
            if ($urandom_range(6) == 0) send_noise();
            else dma_read_burst();
        end
    endtask

    initial begin
        int guard;
        guard        = 0;
        send_gap_pct = 8;
        stall_pct    = 61;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_register_map();
        test_address_carry();
        test_count_and_target();
        test_events_and_empty_grant();
        test_transfers(8, 61, 24'h800000);
        test_transfers(61, 8, 24'h000000);
        test_transfers(0, 0, 24'($urandom_range(24'h800000)));
        i_in_valid <= 1'b0;
        while (beats_due.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        mismatches += beats_due.size();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

FILE: floppy_dma_double_buffer.f
src/fdmadb_pkg.sv
src/fdmadb_ctrl.sv
src/fdmadb_dp.sv
src/floppy_dma_double_buffer.sv
dv/tb.sv
